FILE: hdl/hfua_pkg.sv
`default_nettype none

package hfua_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAGMENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_TS_STEP = 2'd1;

  localparam logic [10:0] MAX_FRAGMENT_RESET  = 11'd1360;
  localparam logic [15:0] VIDEO_TS_STEP_RESET = 16'd3600;
  localparam logic [10:0] LIMIT_MIN           = 11'd16;
  localparam logic [10:0] LIMIT_MAX           = 11'd1398;

  localparam logic [4:0] FU_A_TYPE   = 5'd28;
  localparam logic [4:0] TYPE_SLICE  = 5'd1;
  localparam logic [4:0] TYPE_IDR    = 5'd5;
  localparam logic [10:0] FU_HDR_LEN = 11'd2;

  // one accepted byte, classified: data byte plus optional two header bytes
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  nal_header;
    logic        hdr;
    logic        start_bit;
    logic        end_bit;
    logic [10:0] plen;
    logic        marker;
    logic [15:0] ts;
  } job_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_end;
    logic [10:0] packet_length;
    logic        packet_marker;
    logic [15:0] timestamp_step;
    logic        run_last;
  } res_t;

  function automatic logic [15:0] slice_step(input logic [7:0] hdr_byte,
                                             input logic [15:0] step);
    logic [4:0] t;
    t = hdr_byte[4:0];
    return (t == TYPE_SLICE || t == TYPE_IDR) ? step : 16'd0;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hfua_fifo.sv
`default_nettype none

module hfua_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef SYNTH
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_ok && !pop_ok) |=> (count == $past(count) + CNT_W'(1)))
    else $error("fifo count did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop_ok && !push_ok) |=> (count == $past(count) - CNT_W'(1)))
    else $error("fifo count did not shrink on pop");
`endif

endmodule

`default_nettype wire

FILE: hdl/hfua_front.sv
`default_nettype none

module hfua_front #(
  parameter int NAL_LEN_BITS = 23
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [hfua_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hfua_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             accept,
  input  wire logic [7:0]                       nal_byte,
  input  wire logic [NAL_LEN_BITS-1:0]          nal_length,
  input  wire logic                             first_of_nal,
  output logic                                  job_valid,
  output hfua_pkg::job_t                        job
);

  localparam int SUM_W = NAL_LEN_BITS + 1;

  logic [10:0]             max_fragment;
  logic [15:0]             video_ts_step;

  logic [NAL_LEN_BITS-1:0] rem_unit;
  logic [10:0]             plen_whole;
  logic [10:0]             fragment_fill;
  logic [7:0]              saved_header;
  logic                    fragmenting;
  logic                    start_pending;

  logic [10:0]             lim;
  logic [NAL_LEN_BITS-1:0] len_in;
  logic                    frag_in;
  logic                    last;
  logic [SUM_W-1:0]        rem;
  logic                    fin;
  logic [11:0]             fill_inc;
  logic                    frag_end;

  always_comb begin
    lim = max_fragment;
    if (max_fragment < hfua_pkg::LIMIT_MIN) begin
      lim = hfua_pkg::LIMIT_MIN;
    end else if (max_fragment > hfua_pkg::LIMIT_MAX) begin
      lim = hfua_pkg::LIMIT_MAX;
    end
  end

  assign len_in   = (nal_length == '0) ? NAL_LEN_BITS'(1) : nal_length;
  assign frag_in  = len_in > NAL_LEN_BITS'(lim);
  assign last     = (rem_unit == NAL_LEN_BITS'(1));
  // bytes still to go in the unit from the start of the open fragment
  assign rem      = SUM_W'(rem_unit) + SUM_W'(fragment_fill);
  assign fin      = rem <= SUM_W'(lim);
  assign fill_inc = {1'b0, fragment_fill} + 12'd1;
  assign frag_end = last || (fill_inc >= {1'b0, lim});

  always_comb begin
    job_valid      = 1'b0;
    job.data_byte  = nal_byte;
    job.nal_header = saved_header;
    job.hdr        = 1'b0;
    job.start_bit  = 1'b0;
    job.end_bit    = 1'b0;
    job.plen       = plen_whole;
    job.marker     = 1'b1;
    job.ts         = hfua_pkg::slice_step(saved_header, video_ts_step);
    if (first_of_nal) begin
      job_valid  = accept && !frag_in;
      job.end_bit = (len_in == NAL_LEN_BITS'(1));
      job.plen   = len_in[10:0];
      job.ts     = hfua_pkg::slice_step(nal_byte, video_ts_step);
    end else if (rem_unit != '0) begin
      job_valid = accept;
      if (!fragmenting) begin
        job.end_bit = last;
      end else begin
        job.hdr       = (fragment_fill == '0);
        job.start_bit = start_pending;
        job.end_bit   = frag_end;
        job.plen      = (fin ? rem[10:0] : lim) + hfua_pkg::FU_HDR_LEN;
        job.marker    = fin;
        job.ts        = fin ? video_ts_step : 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fragment  <= hfua_pkg::MAX_FRAGMENT_RESET;
      video_ts_step <= hfua_pkg::VIDEO_TS_STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        hfua_pkg::REG_MAX_FRAGMENT:  max_fragment  <= cfg_data[10:0];
        hfua_pkg::REG_VIDEO_TS_STEP: video_ts_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_unit      <= '0;
      plen_whole    <= '0;
      fragment_fill <= '0;
      saved_header  <= '0;
      fragmenting   <= 1'b0;
      start_pending <= 1'b0;
    end else if (accept) begin
      if (first_of_nal) begin
        rem_unit      <= len_in - NAL_LEN_BITS'(1);
        plen_whole    <= len_in[10:0];
        fragment_fill <= '0;
        saved_header  <= nal_byte;
        fragmenting   <= frag_in;
        start_pending <= 1'b1;
      end else if (rem_unit != '0) begin
        rem_unit <= rem_unit - NAL_LEN_BITS'(1);
        if (fragmenting) begin
          start_pending <= 1'b0;
          fragment_fill <= frag_end ? 11'd0 : fill_inc[10:0];
        end
      end
    end
  end

`ifndef SYNTH
  a_rem_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !first_of_nal && rem_unit != '0)
      |=> (rem_unit == $past(rem_unit) - NAL_LEN_BITS'(1)))
    else $error("unit byte count did not step");

  a_fill_closed: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.end_bit) |=> (fragment_fill == '0))
    else $error("fragment fill not cleared after packet end");
`endif

endmodule

`default_nettype wire

FILE: hdl/hfua_back.sv
`default_nettype none

module hfua_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hfua_pkg::job_t  job,
  input  wire logic            job_empty,
  output logic                 job_pop,
  input  wire logic            res_full,
  output logic                 res_push,
  output hfua_pkg::res_t       res
);

  localparam logic [1:0] PH_IND  = 2'd0;
  localparam logic [1:0] PH_FUH  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  hfua_pkg::job_t cur;
  logic           cur_valid;
  logic [1:0]     phase;
  logic           emit;
  logic           finishing;
  logic           load;

  assign emit      = cur_valid && !res_full;
  assign finishing = emit && (phase == PH_DATA);
  assign load      = !cur_valid || finishing;
  assign job_pop   = load && !job_empty;
  assign res_push  = emit;

  always_comb begin
    res.packet_length  = cur.plen;
    res.packet_marker  = cur.marker;
    res.timestamp_step = cur.ts;
    res.packet_end     = 1'b0;
    res.run_last       = 1'b0;
    case (phase)
      PH_IND:  res.out_byte = {cur.nal_header[7:5], hfua_pkg::FU_A_TYPE};
      PH_FUH:  res.out_byte = {cur.start_bit, cur.marker, 1'b0, cur.nal_header[4:0]};
      PH_DATA: begin
        res.out_byte   = cur.data_byte;
        res.packet_end = cur.end_bit;
        res.run_last   = 1'b1;
      end
      default: res.out_byte = cur.data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_DATA;
    end else if (load) begin
      cur_valid <= !job_empty;
      phase     <= job.hdr ? PH_IND : PH_DATA;
    end else if (emit) begin
      phase <= (phase == PH_IND) ? PH_FUH : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

`ifndef SYNTH
  a_hdr_phase: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && phase != PH_DATA) |-> cur.hdr)
    else $error("header phase on a job without fragment header");

  a_ind_then_fuh: assert property (@(posedge clk) disable iff (rst)
    (emit && phase == PH_IND) |=> (cur_valid && phase == PH_FUH))
    else $error("fu header did not follow indicator");
`endif

endmodule

`default_nettype wire

FILE: hdl/h264_fu_a_packetizer.sv
`default_nettype none

// an accepted byte passes through the job queue, the back end's current-job register
// and the result queue; one result per cycle while the result queue has room, so one
// byte per cycle for whole units; each fu-a fragment also inserts an indicator and fu header
// the front takes a byte per cycle while its 4-entry job queue has room
// reset (synchronous, active high) empties both queues and clears unit state;
// max_fragment returns to 1360 and video_ts_step to 3600
module h264_fu_a_packetizer #(
  parameter int NAL_LEN_BITS = 23
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hfua_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hfua_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       nal_byte,
  input  wire logic [NAL_LEN_BITS-1:0]          nal_length,
  input  wire logic                             first_of_nal,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic [7:0]                            out_byte,
  output logic                                  packet_end,
  output logic [10:0]                           packet_length,
  output logic                                  packet_marker,
  output logic [15:0]                           timestamp_step,
  output logic                                  run_last
);

  localparam int JOB_W = $bits(hfua_pkg::job_t);
  localparam int RES_W = $bits(hfua_pkg::res_t);

  logic           accept;
  logic           job_valid;
  hfua_pkg::job_t job_in;
  hfua_pkg::job_t job_head;
  logic           job_full;
  logic           job_empty;
  logic           job_pop;
  logic           res_push;
  logic           res_full;
  hfua_pkg::res_t res_in;
  hfua_pkg::res_t res_head;

  assign cfg_ready = 1'b1;
  assign full      = job_full;
  assign accept    = push && !job_full;

  hfua_front #(
    .NAL_LEN_BITS(NAL_LEN_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .nal_byte    (nal_byte),
    .nal_length  (nal_length),
    .first_of_nal(first_of_nal),
    .job_valid   (job_valid),
    .job         (job_in)
  );

  hfua_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(4)
  ) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .push (job_valid),
    .din  (job_in),
    .full (job_full),
    .pop  (job_pop),
    .dout (job_head),
    .empty(job_empty)
  );

  hfua_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_head),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  hfua_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_head),
    .empty(empty)
  );

  assign out_byte       = res_head.out_byte;
  assign packet_end     = res_head.packet_end;
  assign packet_length  = res_head.packet_length;
  assign packet_marker  = res_head.packet_marker;
  assign timestamp_step = res_head.timestamp_step;
  assign run_last       = res_head.run_last;

endmodule

`default_nettype wire
